### design/nmc_pkg.sv
// Shared constants and types for the neighborhood motif counter.
package nmc_pkg;

    localparam int MOTIF_SLOTS = 8;
    localparam int LABEL_BITS  = 8;
    localparam int COUNT_BITS  = 32;

    localparam int LABEL_W     = 8;
    localparam int DIST_W      = 32;
    localparam int RADIUS_W    = 16;
    localparam int SIZE_W      = 4;
    localparam int LABELS_W    = 64;
    localparam int COUNT_W     = 32;
    localparam int CFG_IDX_W   = 2;

    typedef logic [MOTIF_SLOTS-1:0] slot_mask_t;
    typedef logic [COUNT_BITS-1:0]  count_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_DIST     = 2'd0,
        CFG_MOTIF_SIZE   = 2'd1,
        CFG_MOTIF_LABELS = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        slot_mask_t in_use;
        logic       any_slot;
    } motif_view_t;

endpackage

### design/nmc_match.sv
// Motif slot compare: picks the lowest unmatched slot in use whose label equals the item.
module nmc_match
    import nmc_pkg::*;
(
    input  logic [LABEL_W-1:0]  label,
    input  slot_mask_t          matched,
    input  logic [LABELS_W-1:0] motif_labels,
    input  logic [SIZE_W-1:0]   motif_size,
    output slot_mask_t          hit,
    output motif_view_t         view
);

    slot_mask_t cand;

    always_comb
    begin
        for (int i = 0; i < MOTIF_SLOTS; i++)
        begin
            view.in_use[i] = motif_size > SIZE_W'(i);
            cand[i] = view.in_use[i] && !matched[i] &&
                      (motif_labels[i*8 +: LABEL_BITS] == label[LABEL_BITS-1:0]);
        end
        view.any_slot = motif_size != '0;
        hit = cand & (~cand + slot_mask_t'(1));
    end

endmodule

### design/neighborhood_motif_counter_unit.sv
// Items pass through the stage-1 registers; a closing item then writes the result register.
// Throughput: one item per cycle, unless a closing item waits on a full, unread result.
// Results come only from items that close a list; other items leave no result.
// Reset clears the configuration registers, match state, counters and valid flags.
// Config writes are taken every cycle and the squared radius is stored on write.
module neighborhood_motif_counter_unit
    import nmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [LABEL_W-1:0]   neighbor_label,
    input  logic [DIST_W-1:0]    dist_sq,
    input  logic                 use_distance,
    input  logic                 first_of_list,
    input  logic                 last_of_list,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 motif_found,
    output logic [COUNT_W-1:0]   near_count,
    output logic [COUNT_W-1:0]   all_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LABELS_W-1:0]  cfg_data
);

    logic [SIZE_W-1:0]   motif_size_reg;
    logic [LABELS_W-1:0] motif_labels_reg;
    logic [DIST_W-1:0]   r2_reg;
    logic [DIST_W-1:0]   radius_ext;

    logic                s1_valid_reg;
    logic [LABEL_W-1:0]  s1_label_reg;
    logic [DIST_W-1:0]   s1_dist_reg;
    logic                s1_use_reg;
    logic                s1_first_reg;
    logic                s1_last_reg;
    logic                s1_advance;

    slot_mask_t          slot_matched_reg;
    slot_mask_t          slot_matched_next;
    logic                first_skipped_reg;
    logic                first_skipped_next;
    count_t              near_counter_reg;
    count_t              near_counter_next;
    count_t              all_counter_reg;
    count_t              all_counter_next;

    logic                out_valid_reg;
    logic                found_reg;
    logic [COUNT_W-1:0]  near_out_reg;
    logic [COUNT_W-1:0]  all_out_reg;

    slot_mask_t          base_matched;
    logic                base_skipped;
    logic                counts;
    slot_mask_t          hit;
    slot_mask_t          marked;
    motif_view_t         view;
    logic                found;

    assign cfg_ready  = 1'b1;
    assign radius_ext = DIST_W'(cfg_data[RADIUS_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            motif_size_reg   <= '0;
            motif_labels_reg <= '0;
            r2_reg           <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                CFG_MAX_DIST:
                begin
                    r2_reg <= radius_ext * radius_ext;
                end
                CFG_MOTIF_SIZE:
                begin
                    motif_size_reg <= cfg_data[SIZE_W-1:0];
                end
                CFG_MOTIF_LABELS:
                begin
                    motif_labels_reg <= cfg_data;
                end
                default:
                begin
                end
            endcase
        end
    end

    // advance unless a closing item waits on a full result register that is not being read
    assign s1_advance = s1_valid_reg && (!s1_last_reg || !out_valid_reg || out_ready);
    assign in_ready   = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_label_reg <= neighbor_label;
            s1_dist_reg  <= dist_sq;
            s1_use_reg   <= use_distance;
            s1_first_reg <= first_of_list;
            s1_last_reg  <= last_of_list;
        end
    end

    nmc_match u_match (
        .label        (s1_label_reg),
        .matched      (base_matched),
        .motif_labels (motif_labels_reg),
        .motif_size   (motif_size_reg),
        .hit          (hit),
        .view         (view)
    );

    always_comb
    begin
        base_matched = s1_first_reg ? '0 : slot_matched_reg;
        base_skipped = s1_first_reg ? 1'b0 : first_skipped_reg;
        counts       = !s1_use_reg || (s1_dist_reg < r2_reg);
        marked       = (counts && base_skipped) ? (base_matched | hit) : base_matched;
        found        = view.any_slot && ((marked | ~view.in_use) == '1);

        slot_matched_next  = s1_last_reg ? '0 : marked;
        first_skipped_next = s1_last_reg ? 1'b0 : (base_skipped || counts);

        near_counter_next = near_counter_reg;
        all_counter_next  = all_counter_reg;
        if (s1_last_reg && found)
        begin
            if (s1_use_reg)
            begin
                if (near_counter_reg != '1)
                begin
                    near_counter_next = near_counter_reg + count_t'(1);
                end
            end
            else
            begin
                if (all_counter_reg != '1)
                begin
                    all_counter_next = all_counter_reg + count_t'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_matched_reg  <= '0;
            first_skipped_reg <= 1'b0;
            near_counter_reg  <= '0;
            all_counter_reg   <= '0;
        end
        else if (s1_advance)
        begin
            slot_matched_reg  <= slot_matched_next;
            first_skipped_reg <= first_skipped_next;
            near_counter_reg  <= near_counter_next;
            all_counter_reg   <= all_counter_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance && s1_last_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance && s1_last_reg)
        begin
            found_reg    <= found;
            near_out_reg <= COUNT_W'(near_counter_next);
            all_out_reg  <= COUNT_W'(all_counter_next);
        end
    end

    assign out_valid   = out_valid_reg;
    assign motif_found = found_reg;
    assign near_count  = near_out_reg;
    assign all_count   = all_out_reg;

    a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
        !(!$stable(near_counter_reg) && !$stable(all_counter_reg)))
        else $error("both counters changed in one cycle");

    a_clear_on_close: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_advance && s1_last_reg) |=> (slot_matched_reg == '0 && !first_skipped_reg))
        else $error("match state not cleared after a closing item");

    a_count_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        (!$stable(near_counter_reg) || !$stable(all_counter_reg)) |->
        ($past(s1_advance && s1_last_reg) && out_valid_reg))
        else $error("counter changed without a result");

endmodule
